>>> rtl/wavx_pkg.sv
// types and constants shared by the wav header and sample extractor
`timescale 1ns / 1ps
package wavx_pkg;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_ERROR  = 2'd1,
		KIND_SAMPLE = 2'd2,
		KIND_PAD    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE    = 4'd0,
		ERR_SHORT   = 4'd1,
		ERR_RIFF    = 4'd2,
		ERR_WAVE    = 4'd3,
		ERR_FMT     = 4'd4,
		ERR_FMT_LEN = 4'd5,
		ERR_RATE    = 4'd6,
		ERR_BITS    = 4'd7,
		ERR_DTAG    = 4'd8,
		ERR_ZBLOCK  = 4'd9,
		ERR_BLOCK   = 4'd10,
		ERR_CHANNEL = 4'd11
	} err_t;

	typedef enum logic [2:0] {
		PH_HDR  = 3'b001,
		PH_DATA = 3'b010,
		PH_STOP = 3'b100
	} phase_t;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] FMT_LEN  = 32'h0000_0010;

	localparam logic [31:0] RATE_MAX  = 32'd25938;
	localparam logic [31:0] RATE_MIN  = 32'd4224;
	localparam logic [31:0] RATE_LONG = 32'd13672;
	localparam logic [15:0] BITS_MAX  = 16'd32;

	localparam logic [31:0] SIGN_EXT16 = 32'hFFFF_0000;
	localparam logic [2:0]  BPS_16BIT  = 3'd2;

	// header byte positions
	localparam logic [5:0] IDX_RIFF   = 6'd3;
	localparam logic [5:0] IDX_WAVE   = 6'd11;
	localparam logic [5:0] IDX_FMT    = 6'd15;
	localparam logic [5:0] IDX_FMTLEN = 6'd19;
	localparam logic [5:0] IDX_CHAN   = 6'd23;
	localparam logic [5:0] IDX_RATE   = 6'd27;
	localparam logic [5:0] IDX_BLOCK  = 6'd33;
	localparam logic [5:0] IDX_BITS   = 6'd35;
	localparam logic [5:0] IDX_LAST   = 6'd43;
	localparam logic [5:0] IDX_DTAG_LO = 6'd36;
	localparam logic [5:0] IDX_DTAG_HI = 6'd40;

	typedef struct packed {
		logic accept;
		logic fail;
		err_t code;
	} hdr_evt_t;

	typedef struct packed {
		logic [15:0] channels;
		logic [14:0] rate;
		logic [15:0] block;
		logic [2:0]  bps;
		logic        long_frame;
	} hdr_info_t;

endpackage

>>> rtl/wavx_if.sv
// handshake channels: byte input, result output and channel select write
`timescale 1ns / 1ps
interface wavx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_end;
	modport source (output valid, data_byte, is_end, input ready);
	modport sink (input valid, data_byte, is_end, output ready);
endinterface

interface wavx_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic [3:0]         error_code;
	logic [9:0]         frame_length;
	logic [15:0]        channel_count;
	logic [14:0]        sample_rate;
	logic signed [31:0] sample_value;
	logic [8:0]         sample_position;
	logic               frame_last;
	logic [8:0]         pad_count;
	modport source (output valid, result_kind, error_code, frame_length, channel_count,
		sample_rate, sample_value, sample_position, frame_last, pad_count, input ready);
	modport sink (input valid, result_kind, error_code, frame_length, channel_count,
		sample_rate, sample_value, sample_position, frame_last, pad_count, output ready);
endinterface

interface wavx_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] selected_channel;
	modport source (output valid, selected_channel, input ready);
	modport sink (input valid, selected_channel, output ready);
endinterface

>>> rtl/wav_header_and_sample_extractor.sv
// Takes a WAV file one byte per word and checks its 44-byte PCM header, then returns
// one sample of the selected channel per complete block. A new word is accepted in
// every cycle while the output is not stalled; a word passes an input register and
// its result, if any, then lands in the result register. Input ready falls only while
// that result register holds a word that the sink has not taken. After a header error
// or the end word the block ignores all input until reset.
`timescale 1ns / 1ps
module wav_header_and_sample_extractor
	import wavx_pkg::*;
#(
	parameter int LONG_FRAME  = 512,
	parameter int SHORT_FRAME = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	wavx_cfg_if.sink     cfg,
	wavx_in_if.sink      byte_in,
	wavx_out_if.source   result_out
);

	logic [7:0]  sel_q;
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	phase_t      phase_q;
	logic        res_v_q;

	logic        advance;
	logic        hdr_byte;
	logic        hdr_end;
	logic        dat_byte;
	logic        dat_end;
	logic        pad_fire;
	logic        res_fire;
	hdr_evt_t    evt;
	hdr_info_t   info;

	logic        smp_fire;
	logic [31:0] smp_value;
	logic [8:0]  smp_pos;
	logic        smp_last;
	logic        smp_pos_nz;
	logic [9:0]  smp_flen;
	logic [8:0]  smp_pad;

	kind_t       kind_n;
	err_t        code_n;
	logic [9:0]  flen_n;
	logic [15:0] chan_n;
	logic [14:0] rate_n;
	logic [31:0] value_n;
	logic [8:0]  pos_n;
	logic        last_n;
	logic [8:0]  pad_n;

	assign cfg.ready     = 1'b1;
	assign advance       = v_s1 && (!res_v_q || result_out.ready);
	assign byte_in.ready = !v_s1 || advance;

	assign hdr_byte = advance && phase_q == PH_HDR && !end_s1;
	assign hdr_end  = advance && phase_q == PH_HDR && end_s1;
	assign dat_byte = advance && phase_q == PH_DATA && !end_s1;
	assign dat_end  = advance && phase_q == PH_DATA && end_s1;
	assign pad_fire = dat_end && smp_pos_nz;
	assign res_fire = evt.accept || evt.fail || smp_fire || pad_fire;

	wavx_hdr u_hdr (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_byte (hdr_byte),
		.step_end  (hdr_end),
		.data_byte (byte_s1),
		.sel_ch    (sel_q),
		.evt       (evt),
		.info      (info)
	);

	wavx_smp #(
		.LONG_FRAME  (LONG_FRAME),
		.SHORT_FRAME (SHORT_FRAME)
	) u_smp (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (evt.accept),
		.step         (dat_byte),
		.data_byte    (byte_s1),
		.sel_ch       (sel_q),
		.info         (info),
		.fire         (smp_fire),
		.value        (smp_value),
		.position     (smp_pos),
		.last         (smp_last),
		.pos_nz       (smp_pos_nz),
		.frame_length (smp_flen),
		.pad          (smp_pad)
	);

	// channel select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (cfg.valid) begin
			sel_q <= cfg.selected_channel;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			v_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.data_byte;
			end_s1  <= byte_in.is_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
		end else begin
			unique case (phase_q)
				PH_HDR: begin
					if (evt.fail) begin
						phase_q <= PH_STOP;
					end else if (evt.accept) begin
						phase_q <= PH_DATA;
					end
				end
				PH_DATA: begin
					if (dat_end) begin
						phase_q <= PH_STOP;
					end
				end
				PH_STOP: begin
					phase_q <= PH_STOP;
				end
				default: begin
					phase_q <= PH_STOP;
				end
			endcase
		end
	end

	// result word contents
	always_comb begin
		kind_n  = KIND_ACCEPT;
		code_n  = ERR_NONE;
		flen_n  = '0;
		chan_n  = '0;
		rate_n  = '0;
		value_n = '0;
		pos_n   = '0;
		last_n  = 1'b0;
		pad_n   = '0;
		priority if (evt.accept) begin
			flen_n = smp_flen;
			chan_n = info.channels;
			rate_n = info.rate;
		end else if (evt.fail) begin
			kind_n = KIND_ERROR;
			code_n = evt.code;
		end else if (smp_fire) begin
			kind_n  = KIND_SAMPLE;
			value_n = smp_value;
			pos_n   = smp_pos;
			last_n  = smp_last;
		end else begin
			kind_n = KIND_PAD;
			pad_n  = smp_pad;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (res_fire) begin
			res_v_q <= 1'b1;
		end else if (result_out.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			result_out.result_kind     <= kind_n;
			result_out.error_code      <= code_n;
			result_out.frame_length    <= flen_n;
			result_out.channel_count   <= chan_n;
			result_out.sample_rate     <= rate_n;
			result_out.sample_value    <= value_n;
			result_out.sample_position <= pos_n;
			result_out.frame_last      <= last_n;
			result_out.pad_count       <= pad_n;
		end
	end

	assign result_out.valid = res_v_q;

	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STOP |-> !res_fire)
		else $error("result produced after stop");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire |-> (!res_v_q || result_out.ready))
		else $error("result register overwritten");

	a_hdr_only: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.accept || evt.fail) |-> phase_q == PH_HDR)
		else $error("header event outside header phase");

	a_smp_only: assert property (@(posedge clk) disable iff (!arst_n)
		smp_fire |-> phase_q == PH_DATA && !evt.accept)
		else $error("sample outside data phase");

	a_accept_enters_data: assert property (@(posedge clk) disable iff (!arst_n)
		evt.accept |=> phase_q == PH_DATA)
		else $error("accept did not enter data phase");

endmodule

>>> rtl/wavx_hdr.sv
// header parser: byte counter, field shift register and header checks
`timescale 1ns / 1ps
module wavx_hdr
	import wavx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step_byte,
	input  logic      step_end,
	input  logic [7:0] data_byte,
	input  logic [7:0] sel_ch,
	output hdr_evt_t  evt,
	output hdr_info_t info
);

	logic [5:0]  cnt_q;
	logic [31:0] shift_q;
	logic [15:0] chan_q;
	logic [14:0] rate_q;
	logic [15:0] block_q;
	logic [2:0]  bps_q;
	logic        long_q;

	logic [31:0] shift_n;
	logic [15:0] half;
	logic [11:0] need;
	logic        fail_b;
	logic        acc_b;
	err_t        code_b;

	assign shift_n = {data_byte, shift_q[31:8]};
	assign half    = shift_n[31:16];
	assign need    = (12'(sel_ch) + 12'd1) * 12'(bps_q);

	always_comb begin
		fail_b = 1'b0;
		acc_b  = 1'b0;
		code_b = ERR_NONE;
		unique case (cnt_q)
			IDX_RIFF: begin
				if (shift_n != TAG_RIFF) begin
					fail_b = 1'b1;
					code_b = ERR_RIFF;
				end
			end
			IDX_WAVE: begin
				if (shift_n != TAG_WAVE) begin
					fail_b = 1'b1;
					code_b = ERR_WAVE;
				end
			end
			IDX_FMT: begin
				if (shift_n != TAG_FMT) begin
					fail_b = 1'b1;
					code_b = ERR_FMT;
				end
			end
			IDX_FMTLEN: begin
				if (shift_n != FMT_LEN) begin
					fail_b = 1'b1;
					code_b = ERR_FMT_LEN;
				end
			end
			IDX_RATE: begin
				if (shift_n > RATE_MAX || shift_n < RATE_MIN) begin
					fail_b = 1'b1;
					code_b = ERR_RATE;
				end
			end
			IDX_BITS: begin
				if (half[2:0] != 3'd0 || half > BITS_MAX) begin
					fail_b = 1'b1;
					code_b = ERR_BITS;
				end
			end
			IDX_LAST: begin
				priority if (block_q == 16'd0) begin
					fail_b = 1'b1;
					code_b = ERR_ZBLOCK;
				end else if (block_q < 16'(need)) begin
					fail_b = 1'b1;
					code_b = ERR_BLOCK;
				end else if (16'(sel_ch) >= chan_q) begin
					fail_b = 1'b1;
					code_b = ERR_CHANNEL;
				end else begin
					acc_b = 1'b1;
				end
			end
			default: begin
				fail_b = 1'b0;
			end
		endcase
	end

	always_comb begin
		evt.accept = step_byte && acc_b;
		evt.fail   = (step_byte && fail_b) || step_end;
		if (step_end) begin
			evt.code = (cnt_q >= IDX_DTAG_LO && cnt_q < IDX_DTAG_HI) ? ERR_DTAG : ERR_SHORT;
		end else begin
			evt.code = code_b;
		end
	end

	assign info.channels   = chan_q;
	assign info.rate       = rate_q;
	assign info.block      = block_q;
	assign info.bps        = bps_q;
	assign info.long_frame = long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			shift_q <= '0;
			chan_q  <= '0;
			rate_q  <= '0;
			block_q <= '0;
			bps_q   <= '0;
			long_q  <= 1'b0;
		end else if (step_byte) begin
			cnt_q   <= cnt_q + 6'd1;
			shift_q <= shift_n;
			if (cnt_q == IDX_CHAN) begin
				chan_q <= half;
			end
			if (cnt_q == IDX_RATE) begin
				rate_q <= shift_n[14:0];
				long_q <= shift_n > RATE_LONG;
			end
			if (cnt_q == IDX_BLOCK) begin
				block_q <= half;
			end
			if (cnt_q == IDX_BITS) begin
				bps_q <= half[5:3];
			end
		end
	end

endmodule

>>> rtl/wavx_smp.sv
// sample gatherer: block byte counter, sample bytes and frame position
`timescale 1ns / 1ps
module wavx_smp
	import wavx_pkg::*;
#(
	parameter int LONG_FRAME  = 512,
	parameter int SHORT_FRAME = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  sel_ch,
	input  hdr_info_t   info,
	output logic        fire,
	output logic [31:0] value,
	output logic [8:0]  position,
	output logic        last,
	output logic        pos_nz,
	output logic [9:0]  frame_length,
	output logic [8:0]  pad
);

	localparam int MAX_FRAME = (LONG_FRAME > SHORT_FRAME) ? LONG_FRAME : SHORT_FRAME;
	localparam int LEN_W     = $clog2(MAX_FRAME + 1);
	localparam int POS_W     = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam logic [LEN_W-1:0] LEN_LONG  = LEN_W'(LONG_FRAME);
	localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(SHORT_FRAME);

	logic [15:0]      kcnt_q;
	logic [31:0]      acc_q;
	logic [POS_W-1:0] pos_q;

	logic [9:0]       first;
	logic [16:0]      diff;
	logic             hit;
	logic [31:0]      acc_n;
	logic [15:0]      kcnt_n;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] pos_inc;

	assign first  = 10'(sel_ch) * 10'(info.bps);
	assign diff   = {1'b0, kcnt_q} - 17'(first);
	assign hit    = !diff[16] && diff[15:0] < 16'(info.bps);
	assign acc_n  = hit ? (acc_q | (32'(data_byte) << {diff[1:0], 3'b000})) : acc_q;
	assign kcnt_n = kcnt_q + 16'd1;
	assign fire   = step && kcnt_n == info.block;

	assign value = (info.bps == BPS_16BIT && acc_n[15]) ? (acc_n | SIGN_EXT16) : acc_n;

	assign len          = info.long_frame ? LEN_LONG : LEN_SHORT;
	assign pos_inc      = LEN_W'(pos_q) + LEN_W'(1);
	assign last         = pos_inc >= len;
	assign position     = 9'(pos_q);
	assign pos_nz       = pos_q != '0;
	assign frame_length = 10'(len);
	assign pad          = 9'(len - LEN_W'(pos_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q <= '0;
			acc_q  <= '0;
			pos_q  <= '0;
		end else if (start) begin
			kcnt_q <= '0;
			acc_q  <= '0;
			pos_q  <= '0;
		end else if (step) begin
			if (fire) begin
				kcnt_q <= '0;
				acc_q  <= '0;
				pos_q  <= last ? '0 : POS_W'(pos_inc);
			end else begin
				kcnt_q <= kcnt_n;
				acc_q  <= acc_n;
			end
		end
	end

endmodule
